/* sv/tfn_pkg.sv */
// Shared widths, constants and sideband types of the face normal and centroid unit.
package tfn_pkg;

  localparam int VERTEX_SLOTS_DEF = 1024;
  localparam int COORD_BITS_DEF   = 32;

  localparam int POS_W     = 32;
  localparam int SLOT_W    = 10;
  localparam int NORM_W    = 18;
  localparam int EDGE_W    = 33;
  localparam int CSUM_W    = 34;
  localparam int CABS_W    = 33;
  localparam int CPROD_W   = 66;
  localparam int PROD_W    = 66;
  localparam int CROSS_W   = 67;
  localparam int MAG_W     = 66;
  localparam int GRP_N     = 9;
  localparam int BL_W      = 7;
  localparam int SH_W      = 6;
  localparam int M_W       = 31;
  localparam int SQ_W      = 62;
  localparam int SUMSQ_W   = 64;
  localparam int ROOT_W    = 32;
  localparam int Q_W       = 17;
  localparam int NUM_W     = 48;

  localparam logic [Q_W-1:0]    ONE_Q16 = 17'd65536;
  // floor(2^34 / 3): centroid divide by three
  localparam logic [CABS_W-1:0] DIV3_K  = 33'h155555555;
  localparam int                DIV3_SH = 34;

  typedef struct packed {
    logic                  last;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][POS_W-1:0] center;
  } tag_t;

  typedef struct packed {
    tag_t                tag;
    logic [2:0][M_W-1:0] m;
  } sq_side_t;

endpackage

/* sv/triangle_face_normal_centroid.sv */
// Triangle face normal and centroid unit: vertex store and full datapath pipeline.
//
//  channel   handshake          payload
//  request   start_i / busy_o   req_type_i, vertex_slot_i, pos_*_i, corner_*_i, last_triangle_i
//  result    done_o strobe      normal_*_o, center_*_o, degenerate_o, end_of_mesh_o
//
// One request is taken every cycle; busy_o never rises. A triangle request gives its
// result through the store read, S1 to S9, the 32-stage square root, the divider's numerator
// and 17 quotient stages, then the result register. Loads write the vertex store, no result.
// Reset clears only the stage valid bits; the vertex store is undefined until written.
// The receiver cannot stall, so results leave in request order without holding.
module triangle_face_normal_centroid #(
  parameter int VERTEX_SLOTS = tfn_pkg::VERTEX_SLOTS_DEF,
  parameter int COORD_BITS   = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [tfn_pkg::SLOT_W-1:0]  vertex_slot_i,
  input  logic [tfn_pkg::POS_W-1:0]   pos_x_i,
  input  logic [tfn_pkg::POS_W-1:0]   pos_y_i,
  input  logic [tfn_pkg::POS_W-1:0]   pos_z_i,
  input  logic [tfn_pkg::SLOT_W-1:0]  corner_a_i,
  input  logic [tfn_pkg::SLOT_W-1:0]  corner_b_i,
  input  logic [tfn_pkg::SLOT_W-1:0]  corner_c_i,
  input  logic                        last_triangle_i,
  output logic                        done_o,
  output logic [tfn_pkg::NORM_W-1:0]  normal_x_o,
  output logic [tfn_pkg::NORM_W-1:0]  normal_y_o,
  output logic [tfn_pkg::NORM_W-1:0]  normal_z_o,
  output logic [tfn_pkg::POS_W-1:0]   center_x_o,
  output logic [tfn_pkg::POS_W-1:0]   center_y_o,
  output logic [tfn_pkg::POS_W-1:0]   center_z_o,
  output logic                        degenerate_o,
  output logic                        end_of_mesh_o
);
  import tfn_pkg::*;

  localparam int AW   = $clog2(VERTEX_SLOTS);
  localparam int IW   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int VW   = 3 * COORD_BITS;
  localparam logic [IW:0] SLOTS_W = (IW+1)'(VERTEX_SLOTS);

  function automatic logic [2:0] lead8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

  assign busy_o = 1'b0;

  // ---------------- request and vertex store ----------------
  logic [SLOT_W-1:0] corner [3];
  logic [IW-1:0]     wide_slot, wide_corner [3];
  logic              slot_ok;
  logic [2:0]        rng_d;
  logic [VW-1:0]     wdata;
  logic [VW-1:0]     rdata [3];

  assign corner[0] = corner_a_i;
  assign corner[1] = corner_b_i;
  assign corner[2] = corner_c_i;
  assign wide_slot = IW'(vertex_slot_i);
  assign slot_ok   = {1'b0, wide_slot} < SLOTS_W;
  assign wdata     = {pos_z_i[COORD_BITS-1:0], pos_y_i[COORD_BITS-1:0],
                      pos_x_i[COORD_BITS-1:0]};

  for (genvar c = 0; c < 3; c++) begin : g_store
    assign wide_corner[c] = IW'(corner[c]);
    assign rng_d[c]       = {1'b0, wide_corner[c]} < SLOTS_W;
    // one copy per corner, all written alike
    tfn_ram #(
      .WIDTH(VW),
      .DEPTH(VERTEX_SLOTS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (start_i && !req_type_i && slot_ok),
      .waddr_i(wide_slot[AW-1:0]),
      .wdata_i(wdata),
      .raddr_i(wide_corner[c][AW-1:0]),
      .rdata_o(rdata[c])
    );
  end

  logic       v0_q, last0_q;
  logic [2:0] rng0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && req_type_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last0_q <= last_triangle_i;
    rng0_q  <= rng_d;
  end

  // ---------------- S1: edges and coordinate sum ----------------
  logic signed [COORD_BITS-1:0] raw  [3][3];
  logic signed [POS_W-1:0]      vpos [3][3];
  logic signed [EDGE_W-1:0]     e0_d [3], e1_d [3], e0_q [3], e1_q [3];
  logic signed [CSUM_W-1:0]     csum_d [3], csum_q [3];
  logic                         v1_q, last1_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        raw[c][k]  = rdata[c][k*COORD_BITS +: COORD_BITS];
        vpos[c][k] = rng0_q[c] ? POS_W'(raw[c][k]) : '0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      e0_d[k]   = EDGE_W'(vpos[1][k]) - EDGE_W'(vpos[0][k]);
      e1_d[k]   = EDGE_W'(vpos[2][k]) - EDGE_W'(vpos[0][k]);
      csum_d[k] = CSUM_W'(vpos[0][k]) + CSUM_W'(vpos[1][k]) + CSUM_W'(vpos[2][k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q    <= e0_d;
    e1_q    <= e1_d;
    csum_q  <= csum_d;
    last1_q <= last0_q;
  end

  // ---------------- S2: cross partial products, centroid magnitude ----------------
  logic signed [PROD_W-1:0] p_d [6], p_q [6];
  logic [CSUM_W-1:0]        cneg_full [3];
  logic [CABS_W-1:0]        cabs2_q [3];
  logic [2:0]               cneg2_q;
  logic                     v2_q, last2_q;

  always_comb begin
    p_d[0] = e0_q[1] * e1_q[2];
    p_d[1] = e0_q[2] * e1_q[1];
    p_d[2] = e0_q[2] * e1_q[0];
    p_d[3] = e0_q[0] * e1_q[2];
    p_d[4] = e0_q[0] * e1_q[1];
    p_d[5] = e0_q[1] * e1_q[0];
    for (int k = 0; k < 3; k++) begin
      cneg_full[k] = csum_q[k][CSUM_W-1] ? CSUM_W'(-csum_q[k]) : CSUM_W'(csum_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    last2_q <= last1_q;
    for (int k = 0; k < 3; k++) begin
      cabs2_q[k] <= cneg_full[k][CABS_W-1:0];
      cneg2_q[k] <= csum_q[k][CSUM_W-1];
    end
  end

  // ---------------- S3: cross product, reciprocal multiply ----------------
  logic signed [CROSS_W-1:0] cross_q [3];
  logic [CPROD_W-1:0]        cprod3_q [3];
  logic [CABS_W-1:0]         cabs3_q [3];
  logic [2:0]                cneg3_q;
  logic                      v3_q, last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      cross_q[k]  <= CROSS_W'(p_q[2*k]) - CROSS_W'(p_q[2*k+1]);
      cprod3_q[k] <= CPROD_W'(cabs2_q[k]) * CPROD_W'(DIV3_K);
    end
    cabs3_q <= cabs2_q;
    cneg3_q <= cneg2_q;
    last3_q <= last2_q;
  end

  // ---------------- S4: magnitudes, centroid correction ----------------
  logic [MAG_W-1:0]  mag_d [3], mag4_q [3];
  logic [POS_W-1:0]  q0 [3], qc [3];
  logic [CSUM_W-1:0] crem [3];
  tag_t              tag4_d, tag4_q;
  logic              v4_q;

  always_comb begin
    tag4_d       = '0;
    tag4_d.last  = last3_q;
    for (int k = 0; k < 3; k++) begin
      tag4_d.neg[k] = cross_q[k][CROSS_W-1];
      mag_d[k]      = cross_q[k][CROSS_W-1] ? MAG_W'(-cross_q[k]) : MAG_W'(cross_q[k]);
      q0[k]         = cprod3_q[k][DIV3_SH +: POS_W];
      // estimate is exact or one short
      crem[k]       = CSUM_W'(cabs3_q[k]) - (CSUM_W'(q0[k]) << 1) - CSUM_W'(q0[k]);
      qc[k]         = (crem[k] >= CSUM_W'(3)) ? q0[k] + POS_W'(1) : q0[k];
      tag4_d.center[k] = cneg3_q[k] ? -qc[k] : qc[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q <= mag_d;
    tag4_q <= tag4_d;
  end

  // ---------------- S5: leading one per byte group ----------------
  logic [8*GRP_N-1:0] orw;
  logic [GRP_N-1:0]   gnz_d, gnz_q;
  logic [2:0]         gpos_d [GRP_N], gpos_q [GRP_N];
  logic [MAG_W-1:0]   mag5_q [3];
  tag_t               tag5_q;
  logic               v5_q;

  always_comb begin
    orw = (8*GRP_N)'(mag4_q[0] | mag4_q[1] | mag4_q[2]);
    for (int g = 0; g < GRP_N; g++) begin
      gnz_d[g]  = |orw[8*g +: 8];
      gpos_d[g] = lead8(orw[8*g +: 8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gnz_q  <= gnz_d;
    gpos_q <= gpos_d;
    mag5_q <= mag4_q;
    tag5_q <= tag4_q;
  end

  // ---------------- S6: bit length ----------------
  logic [BL_W-1:0]  bl_d, bl_q;
  logic [MAG_W-1:0] mag6_q [3];
  tag_t             tag6_q;
  logic             v6_q;

  always_comb begin
    bl_d = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (gnz_q[g]) bl_d = BL_W'(8*g) + BL_W'(gpos_q[g]) + BL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bl_q   <= bl_d;
    mag6_q <= mag5_q;
    tag6_q <= tag5_q;
  end

  // ---------------- S7: scale to 31 bits ----------------
  logic [SH_W-1:0] shamt;
  sq_side_t        side7_d, side7_q;
  logic            v7_q;

  always_comb begin
    shamt           = (bl_q > BL_W'(M_W)) ? SH_W'(bl_q - BL_W'(M_W)) : '0;
    side7_d.tag     = tag6_q;
    side7_d.tag.degen = (bl_q == '0);
    for (int k = 0; k < 3; k++) begin
      side7_d.m[k] = M_W'(mag6_q[k] >> shamt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side7_q <= side7_d;
  end

  // ---------------- S8: squares ----------------
  logic [SQ_W-1:0] sq_q [3];
  sq_side_t        side8_q;
  logic            v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= SQ_W'(side7_q.m[k]) * SQ_W'(side7_q.m[k]);
    end
    side8_q <= side7_q;
  end

  // ---------------- S9: sum of squares ----------------
  logic [SUMSQ_W-1:0] sumsq_q;
  sq_side_t           side9_q;
  logic               v9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sumsq_q <= SUMSQ_W'(sq_q[0]) + SUMSQ_W'(sq_q[1]) + SUMSQ_W'(sq_q[2]);
    side9_q <= side8_q;
  end

  // ---------------- length and division ----------------
  logic                sq_valid, dv_valid;
  logic [ROOT_W-1:0]   len;
  sq_side_t            sq_side;
  logic [2:0][Q_W-1:0] quo;
  tag_t                dv_tag;

  tfn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v9_q),
    .x_i    (sumsq_q),
    .side_i (side9_q),
    .valid_o(sq_valid),
    .root_o (len),
    .side_o (sq_side)
  );

  tfn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_valid),
    .len_i  (len),
    .side_i (sq_side),
    .valid_o(dv_valid),
    .quo_o  (quo),
    .tag_o  (dv_tag)
  );

  // ---------------- result register ----------------
  logic              done_q;
  logic [NORM_W-1:0] norm_d [3], norm_q [3];
  logic [POS_W-1:0]  center_q [3];
  logic              degen_q, eom_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_d[k] = dv_tag.neg[k] ? -NORM_W'(quo[k]) : NORM_W'(quo[k]);
    end
    if (dv_tag.degen) begin
      norm_d[0] = NORM_W'(ONE_Q16);
      norm_d[1] = '0;
      norm_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    degen_q <= dv_tag.degen;
    eom_q   <= dv_tag.last;
    for (int k = 0; k < 3; k++) begin
      center_q[k] <= dv_tag.center[k];
    end
  end

  assign done_o        = done_q;
  assign normal_x_o    = norm_q[0];
  assign normal_y_o    = norm_q[1];
  assign normal_z_o    = norm_q[2];
  assign center_x_o    = center_q[0];
  assign center_y_o    = center_q[1];
  assign center_z_o    = center_q[2];
  assign degenerate_o  = degen_q;
  assign end_of_mesh_o = eom_q;

endmodule

/* sv/tfn_ram.sv */
// Generic single write port, single registered read port RAM.
module tfn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tfn_isqrt.sv */
// Pipelined integer square root, one result bit per stage, sideband carried along.
module tfn_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [tfn_pkg::SUMSQ_W-1:0] x_i,
  input  tfn_pkg::sq_side_t         side_i,
  output logic                      valid_o,
  output logic [tfn_pkg::ROOT_W-1:0] root_o,
  output tfn_pkg::sq_side_t         side_o
);
  import tfn_pkg::*;

  localparam int NSTG = ROOT_W;

  logic               valid_q [NSTG];
  logic [SUMSQ_W-1:0] x_q     [NSTG];
  logic [SUMSQ_W-1:0] res_q   [NSTG];
  sq_side_t           side_q  [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (2 * (NSTG - 1 - j));
    logic               v_in;
    logic [SUMSQ_W-1:0] x_in, res_in, trial, x_d, res_d;
    sq_side_t           s_in;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign x_in   = x_i;
      assign res_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[j-1];
      assign x_in   = x_q[j-1];
      assign res_in = res_q[j-1];
      assign s_in   = side_q[j-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (x_in >= trial) begin
        x_d   = x_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        x_d   = x_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[j]    <= x_d;
      res_q[j]  <= res_d;
      side_q[j] <= s_in;
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign root_o  = res_q[NSTG-1][ROOT_W-1:0];
  assign side_o  = side_q[NSTG-1];

endmodule

/* sv/tfn_div.sv */
// Three-lane pipelined divider: rounded |m| * 2^16 / len, one quotient bit per stage.
module tfn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [tfn_pkg::ROOT_W-1:0] len_i,
  input  tfn_pkg::sq_side_t          side_i,
  output logic                       valid_o,
  output logic [2:0][tfn_pkg::Q_W-1:0] quo_o,
  output tfn_pkg::tag_t              tag_o
);
  import tfn_pkg::*;

  localparam int NSTG = Q_W;

  // numerator stage
  logic                  n_valid_q;
  logic [2:0][NUM_W-1:0] n_rem_q;
  logic [ROOT_W-1:0]     n_den_q;
  tag_t                  n_tag_q;
  logic [2:0][NUM_W-1:0] n_rem_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_rem_d[k] = NUM_W'({side_i.m[k], 16'h0000}) + NUM_W'(len_i[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else begin
      n_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_rem_q <= n_rem_d;
    n_den_q <= len_i;
    n_tag_q <= side_i.tag;
  end

  logic                  valid_q [NSTG];
  logic [2:0][NUM_W-1:0] rem_q   [NSTG];
  logic [2:0][Q_W-1:0]   quo_q   [NSTG];
  logic [ROOT_W-1:0]     den_q   [NSTG];
  tag_t                  tag_q   [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam int QB = NSTG - 1 - j;
    logic                  v_in;
    logic [2:0][NUM_W-1:0] rem_in, rem_d;
    logic [2:0][Q_W-1:0]   quo_in, quo_d;
    logic [ROOT_W-1:0]     den_in;
    logic [NUM_W-1:0]      dsh;
    tag_t                  t_in;

    if (j == 0) begin : g_first
      assign v_in   = n_valid_q;
      assign rem_in = n_rem_q;
      assign quo_in = '0;
      assign den_in = n_den_q;
      assign t_in   = n_tag_q;
    end else begin : g_next
      assign v_in   = valid_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign t_in   = tag_q[j-1];
    end

    always_comb begin
      dsh = NUM_W'(den_in) << QB;
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = rem_in[k];
        quo_d[k] = quo_in[k];
        if (rem_in[k] >= dsh) begin
          rem_d[k]     = rem_in[k] - dsh;
          quo_d[k][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= rem_d;
      quo_q[j] <= quo_d;
      den_q[j] <= den_in;
      tag_q[j] <= t_in;
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];
  assign tag_o   = tag_q[NSTG-1];

endmodule

/* tb/sv/tb_triangle_face_normal_centroid.sv */
// Testbench for the triangle face normal and centroid unit: random and directed requests.
module tb_triangle_face_normal_centroid;
  import tfn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TRI  = 1'b1;

  typedef struct packed {
    logic [NORM_W-1:0] nx, ny, nz;
    logic [POS_W-1:0]  cx, cy, cz;
    logic              degen;
    logic              eom;
  } face_t;

  class face_scoreboard;
    logic signed [POS_W-1:0] px[VERTEX_SLOTS_DEF];
    logic signed [POS_W-1:0] py[VERTEX_SLOTS_DEF];
    logic signed [POS_W-1:0] pz[VERTEX_SLOTS_DEF];
    face_t expected_faces[$];
    int    errors, results, degens;

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   -= res + bitv;
          res  = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note(logic kind, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] x,
                       logic [POS_W-1:0] y, logic [POS_W-1:0] z, logic [SLOT_W-1:0] ia,
                       logic [SLOT_W-1:0] ib, logic [SLOT_W-1:0] ic, logic last);
      logic signed [POS_W-1:0] a[3], b[3], c[3];
      logic signed [EDGE_W-1:0] e0[3], e1[3];
      logic signed [67:0] cr[3];
      logic [67:0] mag[3];
      logic signed [CSUM_W-1:0] sum3;
      longint unsigned m[3], sumsq, len, q;
      int bl, s;
      face_t f;
      if (kind == REQ_LOAD) begin
        px[slot] = x;
        py[slot] = y;
        pz[slot] = z;
        return;
      end
      a = '{px[ia], py[ia], pz[ia]};
      b = '{px[ib], py[ib], pz[ib]};
      c = '{px[ic], py[ic], pz[ic]};
      for (int k = 0; k < 3; k++) begin
        e0[k] = b[k] - a[k];
        e1[k] = c[k] - a[k];
      end
      cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
      cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
      cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
      bl = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
        for (int i = 67; i >= 0; i--)
          if (mag[k][i]) begin
            if (i + 1 > bl) bl = i + 1;
            break;
          end
      end
      f.degen = (bl == 0);
      if (f.degen) begin
        f.nx = NORM_W'(65536);
        f.ny = '0;
        f.nz = '0;
      end else begin
        s = bl > 31 ? bl - 31 : 0;
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
          m[k] = 64'(mag[k] >> s);
          sumsq += m[k] * m[k];
        end
        len = int_sqrt(sumsq);
        for (int k = 0; k < 3; k++) begin
          q = (m[k] * 65536 + (len >> 1)) / len;
          if (q > 65536) q = 65536;
          if (cr[k] < 0) q = -q;
          if (k == 0) f.nx = q[NORM_W-1:0];
          else if (k == 1) f.ny = q[NORM_W-1:0];
          else f.nz = q[NORM_W-1:0];
        end
      end
      // signed divide truncates toward zero
      sum3 = a[0] + b[0] + c[0]; f.cx = POS_W'(sum3 / 3);
      sum3 = a[1] + b[1] + c[1]; f.cy = POS_W'(sum3 / 3);
      sum3 = a[2] + b[2] + c[2]; f.cz = POS_W'(sum3 / 3);
      f.eom = last;
      expected_faces.push_back(f);
    endfunction

    function void check(face_t got);
      face_t want;
      results++;
      if (expected_faces.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_faces.pop_front();
      if (want.degen) degens++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp n=%h/%h/%h c=%h/%h/%h d=%b e=%b",
                    " got n=%h/%h/%h c=%h/%h/%h d=%b e=%b"},
                   want.nx, want.ny, want.nz, want.cx, want.cy, want.cz, want.degen, want.eom,
                   got.nx, got.ny, got.nz, got.cx, got.cy, got.cz, got.degen, got.eom);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic req_type_i = 1'b0;
  logic [SLOT_W-1:0] vertex_slot_i = '0, corner_a_i = '0, corner_b_i = '0, corner_c_i = '0;
  logic [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_triangle_i = 1'b0;
  logic done_o, degenerate_o, end_of_mesh_o;
  logic [NORM_W-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [POS_W-1:0] center_x_o, center_y_o, center_z_o;

  face_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;
  logic [SLOT_W-1:0] written_slots[$];
  bit written[VERTEX_SLOTS_DEF];

  triangle_face_normal_centroid i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note(req_type_i, vertex_slot_i, pos_x_i, pos_y_i, pos_z_i,
                corner_a_i, corner_b_i, corner_c_i, last_triangle_i);
      if (done_o)
        sb.check('{normal_x_o, normal_y_o, normal_z_o, center_x_o, center_y_o, center_z_o,
                   degenerate_o, end_of_mesh_o});
    end
  end

  // one request; holds until taken, then idles cycle by cycle at random
  task automatic push_request(logic kind, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] x,
                              logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                              logic [SLOT_W-1:0] ia, logic [SLOT_W-1:0] ib,
                              logic [SLOT_W-1:0] ic, logic last);
    req_type_i      <= kind;
    vertex_slot_i   <= slot;
    pos_x_i         <= x;
    pos_y_i         <= y;
    pos_z_i         <= z;
    corner_a_i      <= ia;
    corner_b_i      <= ib;
    corner_c_i      <= ic;
    last_triangle_i <= last;
    start_i         <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
    if (kind == REQ_LOAD && !written[slot]) begin
      written[slot] = 1'b1;
      written_slots.push_back(slot);
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
  endtask

  function automatic logic [POS_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return POS_W'($signed($urandom_range(0, 1023)) - 512);
      2: case ($urandom_range(0, 4))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hffffffff;
         endcase
      default: return POS_W'($signed($urandom) >>> $urandom_range(4, 20));
    endcase
  endfunction

  task automatic random_request();
    logic [SLOT_W-1:0] ia, ib, ic;
    if (written_slots.size() < 3 || $urandom_range(0, 99) < 30) begin
      push_request(REQ_LOAD, SLOT_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                   SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom), 1'($urandom));
    end else begin
      ia = written_slots[$urandom_range(0, written_slots.size() - 1)];
      ib = written_slots[$urandom_range(0, written_slots.size() - 1)];
      ic = $urandom_range(0, 9) == 0 ? ib
           : written_slots[$urandom_range(0, written_slots.size() - 1)];
      push_request(REQ_TRI, SLOT_W'($urandom), $urandom, $urandom, $urandom, ia, ib, ic,
                   1'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axis vertices, extremes, degenerate and huge cross products
    idle_pct = 0;
    push_request(REQ_LOAD, 0, 0, 0, 0, 10'h3ff, 10'h3ff, 10'h3ff, 1);
    push_request(REQ_LOAD, 1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
    push_request(REQ_LOAD, 1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 1);
    push_request(REQ_LOAD, 2, 32'h10000, 0, 0, 0, 0, 0, 0);
    push_request(REQ_LOAD, 3, 0, 32'h10000, 0, 0, 0, 0, 0);
    push_request(REQ_LOAD, 4, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0);
    push_request(REQ_LOAD, 5, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    push_request(REQ_LOAD, 6, 32'hffffffff, 1, 32'hfffffffe, 0, 0, 0, 0);
    push_request(REQ_TRI, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 2, 3, 0);
    push_request(REQ_TRI, 0, 0, 0, 0, 0, 3, 2, 1);
    push_request(REQ_TRI, 10'h3ff, 0, 0, 0, 5, 5, 5, 0);
    push_request(REQ_TRI, 0, 0, 0, 0, 0, 1, 1023, 1);
    push_request(REQ_TRI, 0, 0, 0, 0, 1, 4, 5, 0);
    push_request(REQ_TRI, 0, 0, 0, 0, 1023, 4, 5, 1);
    push_request(REQ_TRI, 0, 0, 0, 0, 6, 2, 1023, 0);
    push_request(REQ_TRI, 0, 0, 0, 0, 6, 3, 2, 1);
    start_i <= 1'b0;
    repeat (2) @(posedge clk_i);

    idle_pct = 37;
    repeat (170) random_request();
    idle_pct = 47;
    repeat (170) random_request();
    idle_pct = 0;
    repeat (170) random_request();
    start_i <= 1'b0;

    while (sb.expected_faces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests sent, %0d faces checked (%0d degenerate), %0d slots loaded",
             sent, sb.results, sb.degens, written_slots.size());
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
